/* src/sida_pkg.sv */
// Shared constants, types and cell control bundle for the signed decimal text converter.
package sida_pkg;

	localparam int VALUE_WIDTH = 32;
	// Digits needed for the largest magnitude, 2^(VALUE_WIDTH-1); 1233/4096 approximates log10(2)
	localparam int NUM_DIGITS  = (((VALUE_WIDTH - 1) * 1233) >> 12) + 1;
	localparam int DIG_IDX_W   = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
	localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);

	localparam logic [6:0] CODE_ZERO  = 7'd48;
	localparam logic [6:0] CODE_MINUS = 7'd45;

	typedef logic [3:0] bcd_t;

	typedef struct packed {
		logic clear;
		logic shift;
	} cell_ctrl_t;

	typedef struct packed {
		logic                   neg;
		bcd_t [NUM_DIGITS-1:0]  digits;
	} conv_word_t;

endpackage

/* src/sida_digit_cell.sv */
// One decimal digit cell of the shift-and-add-3 converter row.
module sida_digit_cell
	import sida_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic       shift_in,
	output logic       carry_out,
	output bcd_t       digit
);

	bcd_t digit_q;
	bcd_t adj;

	// add 3 when the digit would reach ten or more after doubling
	always_comb begin
		adj = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
	end

	assign carry_out = adj[3];
	assign digit     = digit_q;

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			digit_q <= 4'd0;
		end else if (ctrl.shift) begin
			digit_q <= {adj[2:0], shift_in};
		end
	end

	a_digit_decimal: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.shift |=> (digit_q <= 4'd9))
		else $error("digit cell left decimal range");

endmodule

/* src/sida_convert.sv */
// Input stage: magnitude shift register driving a row of digit cells.
module sida_convert
	import sida_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          word_valid,
	output conv_word_t                    word,
	input  logic                          take
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]             state_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [VALUE_WIDTH-1:0] mag_q;
	logic                   neg_q;
	logic [VALUE_WIDTH-1:0] mag_in;
	logic                   accept;
	cell_ctrl_t             cell_ctrl;
	logic [NUM_DIGITS-1:0]  carry;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);

	// most negative value wraps to the sign bit alone, the right unsigned magnitude
	assign mag_in = value[VALUE_WIDTH-1] ?
		VALUE_WIDTH'(~value[VALUE_WIDTH-1:0] + 1'b1) : value[VALUE_WIDTH-1:0];

	assign cell_ctrl.clear = accept;
	assign cell_ctrl.shift = (state_q == ST_RUN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
						cnt_q   <= CNT_W'(VALUE_WIDTH);
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q <= mag_in;
			neg_q <= value[VALUE_WIDTH-1];
		end else if (state_q == ST_RUN) begin
			mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
		end
	end

	for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
		logic cell_in;
		if (g == 0) begin : g_first
			assign cell_in = mag_q[VALUE_WIDTH-1];
		end else begin : g_rest
			assign cell_in = carry[g-1];
		end
		sida_digit_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (cell_ctrl),
			.shift_in  (cell_in),
			.carry_out (carry[g]),
			.digit     (word.digits[g])
		);
	end

	assign word.neg   = neg_q;
	assign word_valid = (state_q == ST_DONE);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> !carry[NUM_DIGITS-1])
		else $error("top digit cell overflowed");

	a_done_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (cnt_q == '0))
		else $error("conversion finished early");

endmodule

/* src/sida_emit.sv */
// Output stage: sign and digit sequencing into the output register.
module sida_emit
	import sida_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       word_valid,
	input  conv_word_t word,
	output logic       take,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [6:0] char_code,
	output logic       last
);

	logic                 busy_q;
	logic                 neg_pend_q;
	logic [DIG_IDX_W-1:0] pos_q;
	bcd_t                 dig_q [NUM_DIGITS];
	logic                 out_valid_q;
	logic [6:0]           char_q;
	logic                 last_q;
	logic [DIG_IDX_W-1:0] top_idx;
	logic                 advance;

	// highest non-zero digit; zero leaves index 0 so a single '0' goes out
	always_comb begin
		top_idx = '0;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (word.digits[i] != 4'd0) begin
				top_idx = DIG_IDX_W'(i);
			end
		end
	end

	assign take    = word_valid && !busy_q;
	assign advance = busy_q && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			neg_pend_q  <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				busy_q     <= 1'b1;
				neg_pend_q <= word.neg;
				pos_q      <= top_idx;
			end else if (advance) begin
				if (neg_pend_q) begin
					neg_pend_q <= 1'b0;
				end else if (pos_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					pos_q <= pos_q - 1'b1;
				end
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			for (int i = 0; i < NUM_DIGITS; i++) begin
				dig_q[i] <= word.digits[i];
			end
		end
		if (advance) begin
			if (neg_pend_q) begin
				char_q <= CODE_MINUS;
				last_q <= 1'b0;
			end else begin
				char_q <= CODE_ZERO + {3'b000, dig_q[pos_q]};
				last_q <= (pos_q == '0);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last      = last_q;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (pos_q <= DIG_IDX_W'(NUM_DIGITS - 1)))
		else $error("digit index beyond the digit row");

	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (busy_q && !$past(busy_q)))
		else $error("new word loaded over one in progress");

endmodule

/* src/signed_int_to_decimal_ascii.sv */
// Top level: signed integer to decimal ASCII text converter.
//
// Input channel: in_valid / in_stall with value, a signed two's-complement word of
// VALUE_WIDTH bits. A word is taken on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with char_code (7-bit ASCII) and last. Each
// input word yields its decimal text, most significant digit first, with a leading
// '-' for negative values; last marks the final character. Zero gives a single '0'
// and the most negative value prints exactly. No terminator is sent.
//
// Conversion runs bit-serially through a row of BCD digit cells: one magnitude bit
// per cycle, then the digits wait in the done state until the emitter takes them. The
// first character is registered after the emitter has taken the word; then one
// character per cycle while out_stall is low. Conversion of the next word overlaps
// emission of the current one, so a new word can be taken before the last one is
// fully sent; the word rate is set by the shift through the digit cells.
// A stalled receiver simply holds the output register; emission resumes where it
// stopped. in_stall is high from the cycle after a word is taken until its digits pass
// to the emitter, so a long output stall holds the input off once the next word is done.
// Asynchronous reset (arst_n low) empties both stages and drops out_valid.
module signed_int_to_decimal_ascii
	import sida_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [6:0]                    char_code,
	output logic                          last
);

	// converted digits and sign, handed from the cell row to the emitter
	conv_word_t conv_word;
	logic       conv_valid;
	logic       conv_take;

	sida_convert u_convert (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.value      (value),
		.word_valid (conv_valid),
		.word       (conv_word),
		.take       (conv_take)
	);

	// emitter walks sign then digits from the highest non-zero one downwards
	sida_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (conv_valid),
		.word       (conv_word),
		.take       (conv_take),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.char_code  (char_code),
		.last       (last)
	);

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the signed integer to decimal ASCII text converter.
`timescale 1ns / 100ps

module testbench;
	import sida_pkg::*;

	// Quiet-cycle limit: far above the slowest legal gap between two accepted words
	// (sender gap, conversion through the digit cells, receiver stall per character).
	localparam int QUIET_LIMIT  = 2000;
	// Cycles allowed to pass once the last expected character has arrived.
	localparam int TAIL_CYCLES  = 2 * (VALUE_WIDTH + 2);
	localparam int MAX_GAP      = 18;
	localparam int RANDOM_WORDS = 200;
	localparam int MAX_DIGITS   = 24;

	typedef struct packed {
		logic [6:0] code;
		logic       last;
	} text_char_t;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          in_valid  = 1'b0;
	logic                          in_stall;
	logic signed [VALUE_WIDTH-1:0] value     = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [6:0]                    char_code;
	logic                          last;

	// Characters still owed by the block, oldest first.
	text_char_t expected_text[$];

	// Idling switches, flipped per stretch so that some runs go flat out.
	bit send_idle = 1'b0;
	bit recv_idle = 1'b0;

	int error_count   = 0;
	int words_sent    = 0;
	int chars_checked = 0;
	int quiet_cycles  = 0;

	signed_int_to_decimal_ascii dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.char_code (char_code),
		.last      (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Decimal text of one word: magnitude is kept one bit wider so that the most
	// negative value negates without wrapping back to itself.
	function automatic void predict_text(input logic [VALUE_WIDTH-1:0] num);
		logic [VALUE_WIDTH:0] mag;
		logic [3:0]           digit_buf [MAX_DIGITS];
		int                   ndig;
		bit                   negative;
		text_char_t           ch;
		negative = num[VALUE_WIDTH-1];
		mag      = negative ? ({1'b0, ~num} + 1'b1) : {1'b0, num};
		ndig     = 0;
		// at least one digit, so zero gives a lone '0'
		do begin
			digit_buf[ndig] = 4'(mag % 10);
			mag             = mag / 10;
			ndig++;
		end while (mag != 0);
		if (negative) begin
			ch.code = CODE_MINUS;
			ch.last = 1'b0;
			expected_text.push_back(ch);
		end
		for (int k = ndig - 1; k >= 0; k--) begin
			ch.code = CODE_ZERO + 7'(digit_buf[k]);
			ch.last = (k == 0);
			expected_text.push_back(ch);
		end
	endfunction

	// Offer one word, optionally after an idle gap, and hold it until taken.
	// valid stays high after acceptance so that back-to-back words need no dip.
	task automatic send_number(input logic [VALUE_WIDTH-1:0] num);
		int gap;
		gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= num;
		do @(posedge clk); while (in_stall);
		predict_text(num);
		words_sent++;
	endtask

	// Sender holds off until every owed character has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_text.size() != 0);
	endtask

	// Zero, unit values and both ends of the range, flat out on both sides.
	task automatic test_special_values();
		send_idle = 1'b0;
		recv_idle = 1'b0;
		send_number('0);
		send_number(1);
		send_number(-1);
		send_number({1'b0, {(VALUE_WIDTH-1){1'b1}}});
		send_number({1'b1, {(VALUE_WIDTH-1){1'b0}}});
		send_number({1'b1, {(VALUE_WIDTH-2){1'b0}}, 1'b1});
		wait_drained();
	endtask

	// Odd digit counts from one to nine: runs of nines and negative powers of ten, with idling.
	task automatic test_digit_lengths();
		longint pow;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		pow = 1;
		for (int k = 1; k <= 9; k++) begin
			pow = pow * 10;
			if (k % 2 == 1)
				send_number(VALUE_WIDTH'(pow - 1));
			else
				send_number(VALUE_WIDTH'(-pow));
		end
		wait_drained();
	endtask

	// Alternating bit patterns, so every input bit is seen at both levels.
	task automatic test_bit_patterns();
		send_idle = 1'b0;
		recv_idle = 1'b1;
		send_number({(VALUE_WIDTH/2){2'b01}});
		send_number({(VALUE_WIDTH/2){2'b10}});
		send_number({(VALUE_WIDTH/8){8'h0F}});
		send_number({(VALUE_WIDTH/8){8'hF0}});
		wait_drained();
	endtask

	// Random words of mixed length and sign, idling switched per stretch.
	task automatic test_random_numbers();
		logic [VALUE_WIDTH-1:0] num;
		int                     pick;
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i % 25 == 0) begin
				send_idle = ($urandom_range(0, 3) != 0);
				recv_idle = ($urandom_range(0, 3) != 0);
			end
			pick = $urandom_range(0, 9);
			if (pick < 4)
				num = VALUE_WIDTH'($urandom);
			else if (pick < 7)
				num = VALUE_WIDTH'($urandom_range(0, 999));
			else
				num = VALUE_WIDTH'($urandom) >> $urandom_range(0, VALUE_WIDTH - 1);
			if (pick >= 4 && $urandom_range(0, 1))
				num = -num;
			send_number(num);
			// now and then the sender waits for the output side to empty
			if (i % 50 == 49)
				wait_drained();
		end
		wait_drained();
	endtask

	// Receiver: a fresh stall length for every character.
	initial begin : char_sink
		int hold;
		forever begin
			hold = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Compare every accepted character with the oldest one owed.
	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_text.size() == 0) begin
				$display("%0t: unexpected character, actual code %0d last %0b",
					$time, char_code, last);
				error_count++;
			end else begin
				want = expected_text.pop_front();
				chars_checked++;
				if (char_code !== want.code) begin
					$display("%0t: char_code mismatch, expected %0d actual %0d",
						$time, want.code, char_code);
					error_count++;
				end
				if (last !== want.last) begin
					$display("%0t: last mismatch, expected %0b actual %0b",
						$time, want.last, last);
					error_count++;
				end
			end
		end
	end

	// Watchdog: too long without a word or character moving on either channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: timeout, %0d characters still owed", $time, expected_text.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_special_values();
		test_digit_lengths();
		test_bit_patterns();
		test_random_numbers();

		// let any late stray output show up before judging
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_text.size() != 0) begin
			$display("%0t: %0d characters never arrived", $time, expected_text.size());
			error_count++;
		end

		$display("Converted %0d words, %0d characters compared, %0d errors",
			words_sent, chars_checked, error_count);
		$display("Covered zero, range ends, every text length and random words under stalls");
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
